// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define FOCU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define FOCU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/focu_pkg.sv -----
// ----------------------------------------------------------------------------
// focu_pkg
// Types, codes and constants of the fly camera orientation block.
// ----------------------------------------------------------------------------
package focu_pkg;

  // Event codes
  typedef enum logic [1:0] {
    FUNC_KEY     = 2'd0,
    FUNC_MOUSE   = 2'd1,
    FUNC_SCROLL  = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  // Key move directions
  typedef enum logic [1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_LEFT     = 2'd2,
    DIR_RIGHT    = 2'd3
  } dir_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_SENSITIVITY = 3'd1;
  localparam logic [2:0] CFG_START_X     = 3'd2;
  localparam logic [2:0] CFG_START_Y     = 3'd3;
  localparam logic [2:0] CFG_START_Z     = 3'd4;
  localparam logic [2:0] CFG_START_YAW   = 3'd5;
  localparam logic [2:0] CFG_START_PITCH = 3'd6;

  // Angles in 1/256 degree, held 22 bits wide while wrapping
  localparam int ANG_W = 22;
  localparam logic signed [ANG_W-1:0] FULL_TURN   = 22'sd92160;
  localparam logic signed [ANG_W-1:0] HALF_TURN   = 22'sd46080;
  localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 22'sd22784;
  localparam logic signed [16:0]      HALF_17     = 17'sd46080;
  localparam logic signed [16:0]      QUARTER_17  = 17'sd23040;

  localparam logic [14:0] FOV_MIN   = 15'd256;
  localparam logic [14:0] FOV_MAX   = 15'd23040;
  localparam logic [14:0] FOV_START = 15'd11520;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  // Controller to rotation unit
  typedef struct packed {
    logic               start;
    logic signed [16:0] angle;
  } cordic_req_t;

  // Rotation unit to controller
  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } cordic_rsp_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_K_VEL, ST_K_LATCH, ST_K_MUL, ST_K_ADD,
    ST_M_MULY, ST_M_MULP, ST_M_PITCH, ST_SCROLL, ST_RESTART, ST_WRAP,
    ST_CY_GO, ST_CY_WAIT, ST_CP_GO, ST_CP_WAIT,
    ST_F_MUL0, ST_F_MUL1, ST_F_FIN, ST_OUT
  } state_e;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [22:0] atan_q16(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/focu_in_if.sv -----
// ----------------------------------------------------------------------------
// focu_in_if
// Event request channel: valid, ready and the event fields.
// ----------------------------------------------------------------------------
interface focu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [1:0]         direction;
  logic [15:0]        delta_time;
  logic signed [15:0] x_offset;
  logic signed [15:0] y_offset;
  logic               limit_pitch;

  modport source (output valid, func, direction, delta_time, x_offset, y_offset,
                  limit_pitch, input ready);
  modport sink (input valid, func, direction, delta_time, x_offset, y_offset,
                limit_pitch, output ready);
endinterface

// ----- sv/focu_out_if.sv -----
// ----------------------------------------------------------------------------
// focu_out_if
// Camera state channel: valid, ready and the result fields.
// ----------------------------------------------------------------------------
interface focu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic [14:0]        view_angle;

  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_y, right_z, view_angle, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                right_x, right_y, right_z, view_angle, output ready);
endinterface

// ----- sv/focu_cordic.sv -----
// ----------------------------------------------------------------------------
// focu_cordic
// Iterative rotation-mode CORDIC: sine and cosine in 1.14, one step a cycle.
// ----------------------------------------------------------------------------
module focu_cordic
  import focu_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  localparam int CW = $clog2(STEPS);

  logic               busy_q, done_q, neg_q;
  logic [CW-1:0]      cnt_q;
  logic signed [33:0] x_q, y_q;
  logic signed [26:0] z_q;

  logic signed [16:0] fold_ang;
  logic               fold_neg;
  logic signed [33:0] x_sh, y_sh;
  logic signed [26:0] at;
  logic signed [17:0] x_rnd, y_rnd;
  logic signed [15:0] x_cl, y_cl;

  // Fold the angle into +-90 degrees
  always_comb begin
    fold_ang = req_i.angle;
    fold_neg = 1'b0;
    if (req_i.angle > QUARTER_17) begin
      fold_ang = req_i.angle - HALF_17;
      fold_neg = 1'b1;
    end else if (req_i.angle < -QUARTER_17) begin
      fold_ang = req_i.angle + HALF_17;
      fold_neg = 1'b1;
    end
  end

  assign x_sh = x_q >>> cnt_q;
  assign y_sh = y_q >>> cnt_q;
  assign at   = 27'(atan_q16(5'(cnt_q)));

  // Micro-rotation loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      x_q   <= CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= 27'(fold_ang) <<< 8;
      neg_q <= fold_neg;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + at;
      end
    end
  end

  // Round to 1.14, clamp to unit, undo the fold
  always_comb begin
    x_rnd = 18'((x_q + 34'sd32768) >>> 16);
    y_rnd = 18'((y_q + 34'sd32768) >>> 16);
    if (x_rnd > 18'sd16384)       x_cl = ONE_Q14;
    else if (x_rnd < -18'sd16384) x_cl = -ONE_Q14;
    else                          x_cl = 16'(x_rnd);
    if (y_rnd > 18'sd16384)       y_cl = ONE_Q14;
    else if (y_rnd < -18'sd16384) y_cl = -ONE_Q14;
    else                          y_cl = 16'(y_rnd);
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = neg_q ? -x_cl : x_cl;
  assign rsp_o.sin_v = neg_q ? -y_cl : y_cl;

endmodule

// ----- sv/fly_camera_orientation_update.sv -----
// ----------------------------------------------------------------------------
// fly_camera_orientation_update
// Yaw/pitch fly camera: position, orientation vectors and field of view.
// ----------------------------------------------------------------------------
// One event is handled at a time. The result is offered on the output channel,
// and the next event is taken in the cycle after the result is gone. Most of
// the time goes to the shared CORDIC unit: it runs once for yaw and once for
// pitch, one step a cycle. The rest goes to the single shared multiplier, which
// does the key step, the mouse scaling and the front vector products one at a
// time. For a mouse move or a restart the time also depends on the angle wrap,
// which removes one turn per cycle.
`include "assert_macros.svh"

module fly_camera_orientation_update
  import focu_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  focu_in_if.sink           req_i,
  focu_out_if.source        rsp_o
);

  state_e state_q, state_d;

  // Configuration
  logic [15:0]        speed_q, sens_q;
  logic signed [31:0] start_pos_q [3];
  logic signed [16:0] start_yaw_q;
  logic signed [15:0] start_pitch_q;

  // Camera state
  logic signed [31:0]      pos_q [3];
  logic signed [ANG_W-1:0] yaw_q, pitch_q;
  logic [14:0]             fov_q;
  logic signed [15:0]      front_q [3];
  logic signed [15:0]      right_q [3];

  // Event fields and work registers
  dir_e               dir_q;
  logic [15:0]        dt_q;
  logic signed [15:0] xo_q, yo_q;
  logic               lim_q;
  logic [1:0]         k_q;
  logic [31:0]        vel_q;
  logic signed [15:0] sy_q, cy_q, sp_q, cp_q;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod_d, prod_q;

  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;

  focu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cor_req),
    .rsp_o (cor_rsp)
  );

  // Datapath terms
  logic signed [15:0] vec_k;
  logic               key_sub;
  logic signed [27:0] key_step;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [ANG_W-1:0] dang, pitch_sum;
  logic signed [22:0] fov_tmp;
  logic signed [15:0] prod_q14;
  logic               yaw_ok, pitch_ok;

  always_comb begin
    vec_k    = (dir_q == DIR_FORWARD || dir_q == DIR_BACKWARD) ? front_q[k_q] : right_q[k_q];
    key_sub  = (dir_q == DIR_BACKWARD || dir_q == DIR_LEFT);
    key_step = 28'((prod_q + 50'sd2097152) >>> 22);
    pos_sum  = key_sub ? 34'(pos_q[k_q]) - 34'(key_step) : 34'(pos_q[k_q]) + 34'(key_step);
    if (pos_sum > 34'sd2147483647)       pos_sat = 32'sh7fffffff;
    else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
    else                                 pos_sat = 32'(pos_sum);
    dang      = ANG_W'((prod_q + 50'sd2048) >>> 12);
    pitch_sum = pitch_q + dang;
    fov_tmp   = 23'(signed'({1'b0, fov_q})) - (23'(yo_q) <<< 4);
    prod_q14  = 16'((prod_q + 50'sd8192) >>> 14);
    yaw_ok    = (yaw_q < HALF_TURN) && (yaw_q >= -HALF_TURN);
    pitch_ok  = (pitch_q < HALF_TURN) && (pitch_q >= -HALF_TURN);
  end

  assign prod_d = mul_a * mul_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (func_e'(req_i.func))
            FUNC_KEY:    state_d = ST_K_VEL;
            FUNC_MOUSE:  state_d = ST_M_MULY;
            FUNC_SCROLL: state_d = ST_SCROLL;
            default:     state_d = ST_RESTART;
          endcase
        end
      end
      ST_K_VEL:   state_d = ST_K_LATCH;
      ST_K_LATCH: state_d = ST_K_MUL;
      ST_K_MUL:   state_d = ST_K_ADD;
      ST_K_ADD:   state_d = (k_q == 2'd2) ? ST_CY_GO : ST_K_MUL;
      ST_M_MULY:  state_d = ST_M_MULP;
      ST_M_MULP:  state_d = ST_M_PITCH;
      ST_M_PITCH: state_d = ST_WRAP;
      ST_SCROLL:  state_d = ST_CY_GO;
      ST_RESTART: state_d = ST_WRAP;
      ST_WRAP:    state_d = (yaw_ok && pitch_ok) ? ST_CY_GO : ST_WRAP;
      ST_CY_GO:   state_d = ST_CY_WAIT;
      ST_CY_WAIT: state_d = cor_rsp.done ? ST_CP_GO : ST_CY_WAIT;
      ST_CP_GO:   state_d = ST_CP_WAIT;
      ST_CP_WAIT: state_d = cor_rsp.done ? ST_F_MUL0 : ST_CP_WAIT;
      ST_F_MUL0:  state_d = ST_F_MUL1;
      ST_F_MUL1:  state_d = ST_F_FIN;
      ST_F_FIN:   state_d = ST_OUT;
      ST_OUT:     state_d = rsp_o.ready ? ST_IDLE : ST_OUT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operands
  always_comb begin
    req_i.ready   = (state_q == ST_IDLE);
    rsp_o.valid   = (state_q == ST_OUT);
    cor_req.start = (state_q == ST_CY_GO) || (state_q == ST_CP_GO);
    cor_req.angle = (state_q == ST_CY_GO) ? yaw_q[16:0] : pitch_q[16:0];
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_K_VEL: begin
        mul_a = 33'({1'b0, dt_q});
        mul_b = 17'({1'b0, speed_q});
      end
      ST_K_MUL: begin
        mul_a = 33'({1'b0, vel_q});
        mul_b = 17'(vec_k);
      end
      ST_M_MULY: begin
        mul_a = 33'(xo_q);
        mul_b = 17'({1'b0, sens_q});
      end
      ST_M_MULP: begin
        mul_a = 33'(yo_q);
        mul_b = 17'({1'b0, sens_q});
      end
      ST_F_MUL0: begin
        mul_a = 33'(cp_q);
        mul_b = 17'(cy_q);
      end
      ST_F_MUL1: begin
        mul_a = 33'(cp_q);
        mul_b = 17'(sy_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Work registers without reset
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (req_i.valid && req_i.ready) begin
      dir_q <= dir_e'(req_i.direction);
      dt_q  <= req_i.delta_time;
      xo_q  <= req_i.x_offset;
      yo_q  <= req_i.y_offset;
      lim_q <= req_i.limit_pitch;
    end
    if (state_q == ST_K_LATCH) vel_q <= prod_q[31:0];
    if (state_q == ST_CY_WAIT && cor_rsp.done) begin
      sy_q <= cor_rsp.sin_v;
      cy_q <= cor_rsp.cos_v;
    end
    if (state_q == ST_CP_WAIT && cor_rsp.done) begin
      sp_q <= cor_rsp.sin_v;
      cp_q <= cor_rsp.cos_v;
    end
  end

  // Configuration, camera state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      speed_q        <= 16'd1280;
      sens_q         <= 16'd26214;
      start_pos_q[0] <= '0;
      start_pos_q[1] <= '0;
      start_pos_q[2] <= '0;
      start_yaw_q    <= -17'sd23040;
      start_pitch_q  <= '0;
      pos_q[0]       <= '0;
      pos_q[1]       <= '0;
      pos_q[2]       <= '0;
      yaw_q          <= -22'sd23040;
      pitch_q        <= '0;
      fov_q          <= FOV_START;
      front_q[0]     <= '0;
      front_q[1]     <= '0;
      front_q[2]     <= -ONE_Q14;
      right_q[0]     <= ONE_Q14;
      right_q[1]     <= '0;
      right_q[2]     <= '0;
      k_q            <= '0;
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOVE_SPEED:  speed_q        <= cfg_data_i[15:0];
          CFG_SENSITIVITY: sens_q         <= cfg_data_i[15:0];
          CFG_START_X:     start_pos_q[0] <= cfg_data_i;
          CFG_START_Y:     start_pos_q[1] <= cfg_data_i;
          CFG_START_Z:     start_pos_q[2] <= cfg_data_i;
          CFG_START_YAW:   start_yaw_q    <= cfg_data_i[16:0];
          CFG_START_PITCH: start_pitch_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_K_LATCH: k_q <= '0;
        ST_K_ADD: begin
          pos_q[k_q] <= pos_sat;
          k_q        <= k_q + 2'd1;
        end
        ST_M_MULP: yaw_q <= yaw_q + dang;
        ST_M_PITCH: begin
          if (lim_q) begin
            if (pitch_sum > PITCH_LIMIT)       pitch_q <= PITCH_LIMIT;
            else if (pitch_sum < -PITCH_LIMIT) pitch_q <= -PITCH_LIMIT;
            else                               pitch_q <= pitch_sum;
          end else begin
            pitch_q <= pitch_sum;
          end
        end
        ST_SCROLL: begin
          if (fov_tmp < $signed(23'(FOV_MIN)))      fov_q <= FOV_MIN;
          else if (fov_tmp > $signed(23'(FOV_MAX))) fov_q <= FOV_MAX;
          else                                      fov_q <= 15'(fov_tmp);
        end
        ST_RESTART: begin
          pos_q[0] <= start_pos_q[0];
          pos_q[1] <= start_pos_q[1];
          pos_q[2] <= start_pos_q[2];
          yaw_q    <= ANG_W'(start_yaw_q);
          pitch_q  <= ANG_W'(start_pitch_q);
          fov_q    <= FOV_START;
        end
        // One turn per cycle toward the principal range
        ST_WRAP: begin
          if (yaw_q >= HALF_TURN)        yaw_q <= yaw_q - FULL_TURN;
          else if (yaw_q < -HALF_TURN)   yaw_q <= yaw_q + FULL_TURN;
          if (pitch_q >= HALF_TURN)      pitch_q <= pitch_q - FULL_TURN;
          else if (pitch_q < -HALF_TURN) pitch_q <= pitch_q + FULL_TURN;
        end
        ST_F_MUL1: front_q[0] <= prod_q14;
        ST_F_FIN: begin
          front_q[1] <= sp_q;
          front_q[2] <= prod_q14;
          right_q[1] <= '0;
          if (cp_q < 0) begin
            right_q[0] <= sy_q;
            right_q[2] <= -cy_q;
          end else begin
            right_q[0] <= -sy_q;
            right_q[2] <= cy_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Result payload straight from the camera state
  assign rsp_o.pos_x      = pos_q[0];
  assign rsp_o.pos_y      = pos_q[1];
  assign rsp_o.pos_z      = pos_q[2];
  assign rsp_o.front_x    = front_q[0];
  assign rsp_o.front_y    = front_q[1];
  assign rsp_o.front_z    = front_q[2];
  assign rsp_o.right_x    = right_q[0];
  assign rsp_o.right_y    = right_q[1];
  assign rsp_o.right_z    = right_q[2];
  assign rsp_o.view_angle = fov_q;

  // Checks
  `FOCU_ASSERT_ALWAYS(a_one_side, !(req_i.ready && rsp_o.valid), "ready while result pending")
  `FOCU_ASSERT(a_no_fast_result, (req_i.valid && req_i.ready) |=> !rsp_o.valid, "result too early")
  `FOCU_ASSERT(a_pitch_range, !rsp_o.valid || pitch_ok, "pitch out of range at result")
  `FOCU_ASSERT(a_fov_range, !rsp_o.valid || (fov_q >= FOV_MIN && fov_q <= FOV_MAX), "fov range")

endmodule

// ----- verif/focu_checker.sv -----
// ----------------------------------------------------------------------------
// focu_checker
// Watches the event and camera state channels, predicts each camera state
// from its own copy of the block's state and compares field by field.
// ----------------------------------------------------------------------------
module focu_checker
  import focu_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  focu_in_if          req_i,
  focu_out_if         rsp_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          seen_o
);

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, rx, ry, rz;
    logic [14:0]        fov;
  } cam_t;

  // predictor registers and state
  longint speed, sens, sx, sy, sz, syaw, spitch;
  longint pos[3], yaw, pitch, fov, frontv[3], rightv[3];
  cam_t   cam_q[$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint wrap360(longint v);
    longint r;
    r = v % 92160;
    if (r < -46080) r += 92160;
    if (r >= 46080) r -= 92160;
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // fixed-step rotation CORDIC, outputs in 1.14
  task automatic trig(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit     neg;
    x = 652032875; y = 0; neg = 0;
    if (ang > 23040) begin
      ang -= 46080; neg = 1;
    end else if (ang < -23040) begin
      ang += 46080; neg = 1;
    end
    z = ang * 256;
    for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); y = y + fshr(x, i); z -= longint'(atan_q16(i[4:0]));
      end else begin
        nx = x + fshr(y, i); y = y - fshr(x, i); z += longint'(atan_q16(i[4:0]));
      end
      x = nx;
    end
    x = clip(rshr(x, 16), -16384, 16384);
    y = clip(rshr(y, 16), -16384, 16384);
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic apply_event(input logic [1:0] fn, input logic [1:0] dir,
                             input longint dt, input longint xo, input longint yo,
                             input bit lim);
    longint vel, st, p, dy, dp, sy_, cy_, sp_, cp_;
    cam_t   e;
    case (func_e'(fn))
      FUNC_KEY: begin
        vel = dt * speed;
        for (int i = 0; i < 3; i++) begin
          st = rshr(vel * ((dir == DIR_FORWARD || dir == DIR_BACKWARD) ?
                           frontv[i] : rightv[i]), 22);
          p = (dir == DIR_BACKWARD || dir == DIR_LEFT) ? pos[i] - st : pos[i] + st;
          pos[i] = clip(p, -64'sd2147483648, 64'sd2147483647);
        end
      end
      FUNC_MOUSE: begin
        dy = rshr(xo * sens, 12);
        dp = rshr(yo * sens, 12);
        yaw = wrap360(yaw + dy);
        pitch = lim ? clip(pitch + dp, -22784, 22784) : wrap360(pitch + dp);
      end
      FUNC_SCROLL: fov = clip(fov - 16 * yo, 256, 23040);
      default: begin
        pos[0] = sx; pos[1] = sy; pos[2] = sz;
        yaw = wrap360(syaw); pitch = wrap360(spitch); fov = 11520;
      end
    endcase
    trig(yaw, sy_, cy_);
    trig(pitch, sp_, cp_);
    frontv[0] = rshr(cp_ * cy_, 14);
    frontv[1] = sp_;
    frontv[2] = rshr(cp_ * sy_, 14);
    rightv[0] = cp_ < 0 ? sy_ : -sy_;
    rightv[1] = 0;
    rightv[2] = cp_ < 0 ? -cy_ : cy_;
    e.px = 32'(pos[0]); e.py = 32'(pos[1]); e.pz = 32'(pos[2]);
    e.fx = 16'(frontv[0]); e.fy = 16'(frontv[1]); e.fz = 16'(frontv[2]);
    e.rx = 16'(rightv[0]); e.ry = 16'(rightv[1]); e.rz = 16'(rightv[2]);
    e.fov = 15'(fov);
    cam_q.push_back(e);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    fail_count_o++;
    $display("mismatch %0d: %s got %0d expected %0d", seen_o, what, got, want);
  endtask

  assign pending_o = cam_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cam_t e;
    if (!rst_ni) begin
      speed = 1280; sens = 26214; sx = 0; sy = 0; sz = 0; syaw = -23040; spitch = 0;
      pos[0] = 0; pos[1] = 0; pos[2] = 0; yaw = -23040; pitch = 0; fov = 11520;
      frontv[0] = 0; frontv[1] = 0; frontv[2] = -16384;
      rightv[0] = 16384; rightv[1] = 0; rightv[2] = 0;
      cam_q.delete();
      fail_count_o = 0; seen_o = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOVE_SPEED:  speed = longint'(cfg_data_i[15:0]);
          CFG_SENSITIVITY: sens = longint'(cfg_data_i[15:0]);
          CFG_START_X:     sx = longint'($signed(cfg_data_i));
          CFG_START_Y:     sy = longint'($signed(cfg_data_i));
          CFG_START_Z:     sz = longint'($signed(cfg_data_i));
          CFG_START_YAW:   syaw = longint'($signed(cfg_data_i[16:0]));
          CFG_START_PITCH: spitch = longint'($signed(cfg_data_i[15:0]));
          default: ;
        endcase
      end
      // result check
      if (rsp_o.valid && rsp_o.ready) begin
        seen_o++;
        if (cam_q.size() == 0) begin
          fail_count_o++;
          $display("unexpected camera state at %0d", seen_o);
        end else begin
          e = cam_q.pop_front();
          if (rsp_o.pos_x !== e.px) report("pos_x", rsp_o.pos_x, e.px);
          if (rsp_o.pos_y !== e.py) report("pos_y", rsp_o.pos_y, e.py);
          if (rsp_o.pos_z !== e.pz) report("pos_z", rsp_o.pos_z, e.pz);
          if (rsp_o.front_x !== e.fx) report("front_x", rsp_o.front_x, e.fx);
          if (rsp_o.front_y !== e.fy) report("front_y", rsp_o.front_y, e.fy);
          if (rsp_o.front_z !== e.fz) report("front_z", rsp_o.front_z, e.fz);
          if (rsp_o.right_x !== e.rx) report("right_x", rsp_o.right_x, e.rx);
          if (rsp_o.right_y !== e.ry) report("right_y", rsp_o.right_y, e.ry);
          if (rsp_o.right_z !== e.rz) report("right_z", rsp_o.right_z, e.rz);
          if (rsp_o.view_angle !== e.fov) report("view_angle", rsp_o.view_angle, e.fov);
        end
      end
      // request accepted
      if (req_i.valid && req_i.ready)
        apply_event(req_i.func, req_i.direction, longint'(req_i.delta_time),
                    longint'(req_i.x_offset), longint'(req_i.y_offset),
                    req_i.limit_pitch);
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Fly camera block test: directed events, then random bursts of mouse, key,
// scroll and restart requests across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import focu_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending, seen;
  int          sent = 0;
  bit          calm = 0;

  focu_in_if  req_if ();
  focu_out_if rsp_if ();

  fly_camera_orientation_update uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_if), .rsp_o(rsp_if)
  );

  focu_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_if), .rsp_o(rsp_if),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    req_if.valid = 0; req_if.func = '0; req_if.direction = '0;
    req_if.delta_time = '0; req_if.x_offset = '0; req_if.y_offset = '0;
    req_if.limit_pitch = 0; rsp_if.ready = 0;
  end

  // receiver stalls
  always @(posedge clk_i)
    rsp_if.ready <= calm || ($urandom_range(99) >= 15);

  // valid stays up after acceptance until the next request or an idle cycle
  task automatic send(input func_e fn, input dir_e dir, input logic [15:0] dt,
                      input logic [15:0] xo, input logic [15:0] yo, input bit lim);
    while (!calm && $urandom_range(99) < 15) begin
      req_if.valid <= 0;
      @(posedge clk_i);
    end
    req_if.valid <= 1; req_if.func <= fn; req_if.direction <= dir;
    req_if.delta_time <= dt; req_if.x_offset <= xo; req_if.y_offset <= yo;
    req_if.limit_pitch <= lim;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic drain();
    req_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic rand_item();
    int k;
    k = $urandom_range(99);
    if (k < 40)
      send(FUNC_MOUSE, dir_e'($urandom_range(3)), 16'($urandom), $urandom_range(1) ?
           16'($signed($urandom_range(4000)) - 2000) : 16'($urandom),
           $urandom_range(1) ? 16'($signed($urandom_range(4000)) - 2000) : 16'($urandom),
           1'($urandom_range(1)));
    else if (k < 80)
      send(FUNC_KEY, dir_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
           16'($urandom), 1'($urandom_range(1)));
    else if (k < 93)
      send(FUNC_SCROLL, dir_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
           $urandom_range(1) ? 16'($signed($urandom_range(200)) - 100) : 16'($urandom),
           1'($urandom_range(1)));
    else
      send(FUNC_RESTART, dir_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
           16'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: every event kind and field extremes
    send(FUNC_KEY, DIR_FORWARD, 16'hFFFF, 0, 0, 0);
    send(FUNC_KEY, DIR_BACKWARD, 16'hFFFF, 0, 0, 0);
    send(FUNC_KEY, DIR_LEFT, 16'h8000, 0, 0, 0);
    send(FUNC_KEY, DIR_RIGHT, 16'h0000, 0, 0, 0);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 16'h7FFF, 16'h7FFF, 1);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 16'h8000, 16'h8000, 1);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 16'h7FFF, 16'h7FFF, 0);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 16'h8000, 16'h8000, 0);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 16'h0001, 16'hFFFF, 0);
    send(FUNC_SCROLL, DIR_FORWARD, 0, 0, 16'h7FFF, 0);
    send(FUNC_SCROLL, DIR_FORWARD, 0, 0, 16'h8000, 0);
    send(FUNC_SCROLL, DIR_FORWARD, 0, 0, 16'd100, 0);
    send(FUNC_RESTART, DIR_FORWARD, 0, 0, 0, 0);
    // pitch at minus eighty-nine degrees, then past minus ninety: cos pitch near zero, then negative
    drain();
    write_reg(CFG_SENSITIVITY, 32'd65535);
    write_reg(CFG_START_PITCH, 32'(-16'sd22784));
    write_reg(CFG_START_YAW, 32'(17'sd46079));
    send(FUNC_RESTART, DIR_FORWARD, 0, 0, 0, 0);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 0, 16'd16, 0);
    send(FUNC_KEY, DIR_RIGHT, 16'hFFFF, 0, 0, 0);
    send(FUNC_MOUSE, DIR_FORWARD, 0, 0, 16'd5610, 0);
    send(FUNC_KEY, DIR_LEFT, 16'hFFFF, 0, 0, 0);

    // phases of random traffic under varied registers, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_MOVE_SPEED, ph == 0 ? 32'd65535 : (ph == 1 ? 32'd0 : $urandom));
      write_reg(CFG_SENSITIVITY, ph == 0 ? 32'd65535 : (ph == 1 ? 32'd0 : $urandom));
      write_reg(CFG_START_X, ph == 0 ? 32'h7FFF_FFF0 : (ph == 1 ? 32'h8000_0000 : $urandom));
      write_reg(CFG_START_Y, ph == 0 ? 32'h8000_0010 : (ph == 1 ? 32'h7FFF_FFFF : $urandom));
      write_reg(CFG_START_Z, $urandom);
      write_reg(CFG_START_YAW, ph == 0 ? 32'(-17'sd46080) :
                32'(17'($signed($urandom_range(92159)) - 46080)));
      write_reg(CFG_START_PITCH, ph == 0 ? 32'(16'sd22784) :
                32'(16'($signed($urandom_range(45568)) - 22784)));
      send(FUNC_RESTART, DIR_FORWARD, 0, 0, 0, 0);
      calm = (ph == 3);
      repeat (250) rand_item();
      calm = 0;
    end
    drain();

    $display("covered %0d requests over six register settings, %0d states checked",
             sent, seen);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
